>>> hw/rtl/tpd_pkg.sv
// Shared types and constants of the touch packet stream deframer.
// Used by tpd_front, tpd_back and touch_packet_stream_deframer_core.
package tpd_pkg;

   // frame layout
   localparam int HEAD_LEN       = 4;
   localparam int HELLO_LEN      = 11;
   localparam int PINGPONG_LEN   = 8;
   localparam int HAPTIC_LEN     = 1;
   localparam int TOUCH_HEAD_LEN = 5;
   localparam int CONTACT_LEN    = 6;
   localparam int PAY_BYTES      = 11;
   localparam int RESULT_CAP     = 14;
   localparam int TDATA_W        = 160;

   // packet kinds
   localparam logic [2:0] KIND_HELLO   = 3'd0;
   localparam logic [2:0] KIND_TOUCH   = 3'd1;
   localparam logic [2:0] KIND_CONTACT = 3'd2;
   localparam logic [2:0] KIND_PING    = 3'd3;
   localparam logic [2:0] KIND_PONG    = 3'd4;
   localparam logic [2:0] KIND_HAPTIC  = 3'd5;
   localparam logic [2:0] KIND_NONE    = 3'd7;

   // register indexes
   localparam logic [2:0] REG_MAGIC  = 3'd0;
   localparam logic [2:0] REG_HELLO  = 3'd1;
   localparam logic [2:0] REG_TOUCH  = 3'd2;
   localparam logic [2:0] REG_PING   = 3'd3;
   localparam logic [2:0] REG_PONG   = 3'd4;
   localparam logic [2:0] REG_HAPTIC = 3'd5;
   localparam logic [2:0] REG_TIP    = 3'd6;
   localparam logic [2:0] REG_CONF   = 3'd7;

   typedef struct packed {
      logic [7:0] magic_byte;
      logic [7:0] code_hello;
      logic [7:0] code_touch;
      logic [7:0] code_ping;
      logic [7:0] code_pong;
      logic [7:0] code_haptic;
      logic [7:0] tip_mask;
      logic [7:0] confidence_mask;
   } cfg_type;

   // one queued byte, tagged by the front end
   typedef struct packed {
      logic [7:0] data;
      logic       magic;
   } q_entry_type;

   typedef struct packed {
      logic [2:0]  packet_kind;
      logic        run_last;
      logic [31:0] first_word;
      logic [31:0] second_word;
      logic [7:0]  small_value;
      logic        tip_flag;
      logic        confidence_flag;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [7:0]  rotation_code;
      logic [7:0]  contact_limit;
      logic [31:0] skip_total;
   } res_type;

endpackage

>>> hw/rtl/tpd_front.sv
// Front end: two-entry byte queue that tags each byte as magic or not.
// Depends on tpd_pkg.
module tpd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  tpd_pkg::cfg_type     cfg,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,    // [7:0] rx_byte
   output logic                 q_vld,
   input  logic                 q_rdy,
   output tpd_pkg::q_entry_type q_data
);

   tpd_pkg::q_entry_type entry_ff [2];
   tpd_pkg::q_entry_type entry_in;
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign req_tready = (count_ff != 2'd2);
   assign q_vld      = (count_ff != 2'd0);
   assign q_data     = entry_ff[rptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_vld && q_rdy;

   // classify and advance pointers
   always_comb begin
      entry_in.data  = req_tdata;
      entry_in.magic = (req_tdata == cfg.magic_byte);
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= entry_in;
      end
   end

endmodule

>>> hw/rtl/tpd_back.sv
// Back end: circular byte store, byte-serial frame parser, contact read-back
// and the result holding stages. Depends on tpd_pkg.
module tpd_back #(
   parameter int STORE_DEPTH  = 128,
   parameter int MAX_CONTACTS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tpd_pkg::cfg_type     cfg,
   input  logic                 q_vld,
   output logic                 q_rdy,
   input  tpd_pkg::q_entry_type q_data,
   output logic                 out_vld,
   input  logic                 out_rdy,
   output tpd_pkg::res_type     out_res
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int FW = $clog2(STORE_DEPTH + 1);
   localparam int CW = $clog2(MAX_CONTACTS + 1);
   localparam int PAY_SLOTS = tpd_pkg::PAY_BYTES;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ISSUE  = 3'd1;
   localparam logic [2:0] ST_DATA   = 3'd2;
   localparam logic [2:0] ST_CISSUE = 3'd3;
   localparam logic [2:0] ST_CDATA  = 3'd4;
   localparam logic [2:0] ST_FLUSH  = 3'd5;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [FW-1:0] off);
      logic [FW:0] s;
      s = (FW+1)'(base) + (FW+1)'(off);
      if (s >= (FW+1)'(STORE_DEPTH)) s = s - (FW+1)'(STORE_DEPTH);
      return s[AW-1:0];
   endfunction

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rd_data_ff;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] pos_ff, pos_in;
   logic [31:0]   skip_ff, skip_in;
   logic [2:0]    kind_ff, kind_in;
   logic [7:0]    len_lo_ff, len_lo_in;
   logic [15:0]   len_ff, len_in;
   logic [CW-1:0] ncont_ff, ncont_in;
   logic [7:0]    pay_ff [PAY_SLOTS];
   logic [7:0]    pay_in [PAY_SLOTS];
   logic [AW-1:0] wptr_ff, wptr_in;
   logic [2:0]    cidx_ff, cidx_in;
   logic [CW-1:0] cleft_ff, cleft_in;
   logic [7:0]    cbuf_ff [5];
   logic [7:0]    cbuf_in [5];
   logic [3:0]    rcnt_ff, rcnt_in;
   tpd_pkg::res_type pend_ff, pend_in, out_ff, out_in;
   logic          pend_vld_ff, pend_vld_in, out_vld_ff, out_vld_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic          feed_en, feed_m;
   logic [7:0]    feed_b;
   logic          push_en, flush_en, rcnt_clr;
   tpd_pkg::res_type push_res, done_res, cont_res;
   logic          out_free, can_push;
   logic [FW-1:0] jj;
   logic [7:0]    pv [PAY_SLOTS];
   logic [15:0]   len_full;
   logic          len_ok, tmatch, fits;
   logic [CW-1:0] tn;
   logic [2:0]    kind_code;
   logic [FW-1:0] flen;
   logic          at_end;

   assign out_free = !out_vld_ff || out_rdy;
   assign can_push = !pend_vld_ff || out_free;
   assign out_vld  = out_vld_ff;
   assign out_res  = out_ff;
   assign jj       = pos_ff - FW'(4);
   assign flen     = FW'(len_ff + 16'd4);
   assign at_end   = (17'(pos_ff) + 17'd1) == (17'(len_ff) + 17'd4);
   assign len_full = {feed_b, len_lo_ff};

   // payload view including the byte being fed
   always_comb begin
      for (int i = 0; i < PAY_SLOTS; i++) pv[i] = pay_ff[i];
      if (pos_ff >= FW'(4) && jj < FW'(PAY_SLOTS)) pv[jj[3:0]] = feed_b;
   end

   // type code lookup, first match wins
   always_comb begin
      if (feed_b == cfg.code_hello)       kind_code = tpd_pkg::KIND_HELLO;
      else if (feed_b == cfg.code_touch)  kind_code = tpd_pkg::KIND_TOUCH;
      else if (feed_b == cfg.code_ping)   kind_code = tpd_pkg::KIND_PING;
      else if (feed_b == cfg.code_pong)   kind_code = tpd_pkg::KIND_PONG;
      else if (feed_b == cfg.code_haptic) kind_code = tpd_pkg::KIND_HAPTIC;
      else                                kind_code = tpd_pkg::KIND_NONE;
   end

   // length check against the type
   always_comb begin
      len_ok = len_full <= 16'(STORE_DEPTH - tpd_pkg::HEAD_LEN);
      tmatch = 1'b0;
      tn     = '0;
      for (int k = 0; k <= MAX_CONTACTS; k++) begin
         if (len_full == 16'(tpd_pkg::TOUCH_HEAD_LEN + tpd_pkg::CONTACT_LEN * k)) begin
            tmatch = 1'b1;
            tn     = CW'(k);
         end
      end
      case (kind_ff)
         tpd_pkg::KIND_HELLO:  fits = len_ok && len_full == 16'(tpd_pkg::HELLO_LEN);
         tpd_pkg::KIND_PING,
         tpd_pkg::KIND_PONG:   fits = len_ok && len_full == 16'(tpd_pkg::PINGPONG_LEN);
         tpd_pkg::KIND_HAPTIC: fits = len_ok && len_full == 16'(tpd_pkg::HAPTIC_LEN);
         tpd_pkg::KIND_TOUCH:  fits = len_ok && tmatch;
         default:              fits = 1'b0;
      endcase
   end

   // result of a completed frame
   always_comb begin
      done_res             = '0;
      done_res.packet_kind = kind_ff;
      done_res.skip_total  = skip_ff;
      case (kind_ff)
         tpd_pkg::KIND_HELLO: begin
            done_res.small_value   = pv[0];
            done_res.pos_x         = {pv[2], pv[1]};
            done_res.pos_y         = {pv[4], pv[3]};
            done_res.second_word   = {pv[8], pv[7], pv[6], pv[5]};
            done_res.rotation_code = pv[9];
            done_res.contact_limit = pv[10];
         end
         tpd_pkg::KIND_PING,
         tpd_pkg::KIND_PONG: begin
            done_res.first_word  = {pv[3], pv[2], pv[1], pv[0]};
            done_res.second_word = {pv[7], pv[6], pv[5], pv[4]};
         end
         tpd_pkg::KIND_HAPTIC: begin
            done_res.small_value = pv[0];
         end
         default: begin
            done_res.first_word  = {pv[3], pv[2], pv[1], pv[0]};
            done_res.small_value = pv[4];
         end
      endcase
   end

   // result of one contact, last byte straight from the store read
   always_comb begin
      cont_res                 = '0;
      cont_res.packet_kind     = tpd_pkg::KIND_CONTACT;
      cont_res.skip_total      = skip_ff;
      cont_res.small_value     = cbuf_ff[0];
      cont_res.tip_flag        = (cbuf_ff[1] & cfg.tip_mask) != 8'd0;
      cont_res.confidence_flag = (cbuf_ff[1] & cfg.confidence_mask) != 8'd0;
      cont_res.pos_x           = {cbuf_ff[3], cbuf_ff[2]};
      cont_res.pos_y           = {rd_data_ff, cbuf_ff[4]};
   end

   // sequencer and parser
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      fill_in   = fill_ff;
      pos_in    = pos_ff;
      skip_in   = skip_ff;
      kind_in   = kind_ff;
      len_lo_in = len_lo_ff;
      len_in    = len_ff;
      ncont_in  = ncont_ff;
      for (int i = 0; i < PAY_SLOTS; i++) pay_in[i] = pay_ff[i];
      wptr_in   = wptr_ff;
      cidx_in   = cidx_ff;
      cleft_in  = cleft_ff;
      for (int i = 0; i < 5; i++) cbuf_in[i] = cbuf_ff[i];
      q_rdy     = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = wrap_add(head_ff, fill_ff);
      rd_en     = 1'b0;
      rd_addr   = wrap_add(head_ff, pos_ff);
      feed_en   = 1'b0;
      feed_b    = q_data.data;
      feed_m    = q_data.magic;
      push_en   = 1'b0;
      push_res  = done_res;
      flush_en  = 1'b0;
      rcnt_clr  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_vld) begin
               q_rdy = 1'b1;
               wr_en = 1'b1;
               if (fill_ff == FW'(STORE_DEPTH)) begin
                  // store full: oldest byte goes, rescan from the head
                  head_in  = wrap_add(head_ff, FW'(1));
                  skip_in  = skip_ff + 32'd1;
                  pos_in   = '0;
                  state_in = ST_ISSUE;
               end else begin
                  fill_in  = fill_ff + FW'(1);
                  feed_en  = 1'b1;
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_ISSUE: begin
            if (pos_ff < fill_ff) begin
               rd_en    = 1'b1;
               state_in = ST_DATA;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_DATA: begin
            feed_b = rd_data_ff;
            feed_m = (rd_data_ff == cfg.magic_byte);
            if (can_push) begin
               feed_en  = 1'b1;
               state_in = ST_ISSUE;
            end
         end
         ST_CISSUE: begin
            rd_en    = 1'b1;
            rd_addr  = wptr_ff;
            wptr_in  = wrap_add(wptr_ff, FW'(1));
            state_in = ST_CDATA;
         end
         ST_CDATA: begin
            if (cidx_ff != 3'd5) begin
               cbuf_in[cidx_ff] = rd_data_ff;
               cidx_in  = cidx_ff + 3'd1;
               state_in = ST_CISSUE;
            end else if (can_push) begin
               push_en  = 1'b1;
               push_res = cont_res;
               cidx_in  = 3'd0;
               cleft_in = cleft_ff - CW'(1);
               state_in = (cleft_ff == CW'(1)) ? ST_ISSUE : ST_CISSUE;
            end
         end
         ST_FLUSH: begin
            if (!pend_vld_ff) begin
               rcnt_clr = 1'b1;
               state_in = ST_IDLE;
            end else if (out_free) begin
               flush_en = 1'b1;
               rcnt_clr = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // one byte into the frame parser
      if (feed_en) begin
         logic drop, done;
         drop = 1'b0;
         done = 1'b0;
         case (pos_ff)
            FW'(0): drop = !feed_m;
            FW'(1): kind_in = kind_code;
            FW'(2): len_lo_in = feed_b;
            FW'(3): begin
               drop     = !fits;
               len_in   = len_full;
               ncont_in = tn;
            end
            default: begin
               for (int i = 0; i < PAY_SLOTS; i++) pay_in[i] = pv[i];
               if (at_end) begin
                  if (kind_ff == tpd_pkg::KIND_TOUCH && pv[4] != 8'(ncont_ff)) drop = 1'b1;
                  else done = 1'b1;
               end
            end
         endcase
         if (drop) begin
            head_in  = wrap_add(head_ff, FW'(1));
            fill_in  = fill_in - FW'(1);
            skip_in  = skip_ff + 32'd1;
            pos_in   = '0;
            state_in = ST_ISSUE;
         end else if (done) begin
            head_in  = wrap_add(head_ff, flen);
            fill_in  = fill_in - flen;
            pos_in   = '0;
            push_en  = 1'b1;
            push_res = done_res;
            if (kind_ff == tpd_pkg::KIND_TOUCH && ncont_ff != '0) begin
               wptr_in  = wrap_add(head_ff,
                                   FW'(tpd_pkg::HEAD_LEN + tpd_pkg::TOUCH_HEAD_LEN));
               cidx_in  = 3'd0;
               cleft_in = ncont_ff;
               state_in = ST_CISSUE;
            end else begin
               state_in = ST_ISSUE;
            end
         end else begin
            pos_in = pos_ff + FW'(1);
         end
      end
   end

   // result holding: one pending result, released as last when the byte is done
   always_comb begin
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      out_in      = out_ff;
      out_vld_in  = out_vld_ff && !out_rdy;
      rcnt_in     = rcnt_clr ? 4'd0 : rcnt_ff;
      if (push_en && rcnt_ff < 4'(tpd_pkg::RESULT_CAP)) begin
         if (pend_vld_ff) begin
            out_in          = pend_ff;
            out_in.run_last = 1'b0;
            out_vld_in      = 1'b1;
         end
         pend_in     = push_res;
         pend_vld_in = 1'b1;
         rcnt_in     = rcnt_ff + 4'd1;
      end
      if (flush_en) begin
         out_in          = pend_ff;
         out_in.run_last = 1'b1;
         out_vld_in      = 1'b1;
         pend_vld_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         fill_ff     <= '0;
         pos_ff      <= '0;
         skip_ff     <= '0;
         rcnt_ff     <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         fill_ff     <= fill_in;
         pos_ff      <= pos_in;
         skip_ff     <= skip_in;
         rcnt_ff     <= rcnt_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      len_lo_ff <= len_lo_in;
      len_ff    <= len_in;
      ncont_ff  <= ncont_in;
      pay_ff    <= pay_in;
      wptr_ff   <= wptr_in;
      cidx_ff   <= cidx_in;
      cleft_ff  <= cleft_in;
      cbuf_ff   <= cbuf_in;
      pend_ff   <= pend_in;
      out_ff    <= out_in;
   end

   // byte store
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= q_data.data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(STORE_DEPTH))
      else $error("fill count beyond store depth");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= fill_ff)
      else $error("parser position beyond fill count");
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_vld_ff)
      else $error("pending result left over at byte boundary");
   a_cap: assert property (@(posedge clock) disable iff (reset)
      rcnt_ff <= 4'(tpd_pkg::RESULT_CAP))
      else $error("result count beyond cap");
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      flush_en |=> out_vld_ff && out_ff.run_last)
      else $error("flushed result not marked last");

endmodule

>>> hw/rtl/touch_packet_stream_deframer_core.sv
// Touch packet stream deframer, top level: configuration registers, front
// queue and back engine. Depends on tpd_pkg, tpd_front and tpd_back.
//
// One received byte enters per req_ transfer. A byte that extends a waiting
// frame is appended by the back engine in ST_IDLE and then released at the
// end of the byte in ST_FLUSH. When a header is rejected the buffered bytes
// behind it are walked again, each read from the byte store in ST_ISSUE and
// fed to the parser in ST_DATA; a touch frame's contacts are read back from
// the store byte by byte through ST_CISSUE and ST_CDATA. A two-entry queue
// takes bytes while the engine works. Results of one byte leave in order, the
// last one with rsp_tlast set; at most fourteen results are given per byte.
module touch_packet_stream_deframer_core #(
   parameter int STORE_DEPTH  = 128,
   parameter int MAX_CONTACTS = 10
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // first_word, second_word, small_value, tip_flag, confidence_flag,
   // pos_x, pos_y, rotation_code, contact_limit, skip_total, zero pad
   output logic [tpd_pkg::TDATA_W-1:0] rsp_tdata,
   output logic [2:0]   rsp_tuser,   // [2:0] packet_kind
   output logic         rsp_tlast,   // run_last
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [7:0]   csr_data
);

   tpd_pkg::cfg_type     cfg_ff, cfg_in;
   tpd_pkg::q_entry_type q_data;
   tpd_pkg::res_type     res;
   logic                 q_vld, q_rdy;

   assign csr_ready = 1'b1;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            tpd_pkg::REG_MAGIC:  cfg_in.magic_byte      = csr_data;
            tpd_pkg::REG_HELLO:  cfg_in.code_hello      = csr_data;
            tpd_pkg::REG_TOUCH:  cfg_in.code_touch      = csr_data;
            tpd_pkg::REG_PING:   cfg_in.code_ping       = csr_data;
            tpd_pkg::REG_PONG:   cfg_in.code_pong       = csr_data;
            tpd_pkg::REG_HAPTIC: cfg_in.code_haptic     = csr_data;
            tpd_pkg::REG_TIP:    cfg_in.tip_mask        = csr_data;
            tpd_pkg::REG_CONF:   cfg_in.confidence_mask = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_byte      <= 8'd165;
         cfg_ff.code_hello      <= 8'd1;
         cfg_ff.code_touch      <= 8'd2;
         cfg_ff.code_ping       <= 8'd3;
         cfg_ff.code_pong       <= 8'd4;
         cfg_ff.code_haptic     <= 8'd5;
         cfg_ff.tip_mask        <= 8'd1;
         cfg_ff.confidence_mask <= 8'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_vld      (q_vld),
      .q_rdy      (q_rdy),
      .q_data     (q_data)
   );

   tpd_back #(
      .STORE_DEPTH  (STORE_DEPTH),
      .MAX_CONTACTS (MAX_CONTACTS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_vld   (q_vld),
      .q_rdy   (q_rdy),
      .q_data  (q_data),
      .out_vld (rsp_tvalid),
      .out_rdy (rsp_tready),
      .out_res (res)
   );

   // result packing
   assign rsp_tuser = res.packet_kind;
   assign rsp_tlast = res.run_last;
   assign rsp_tdata = {6'd0, res.skip_total, res.contact_limit, res.rotation_code,
                       res.pos_y, res.pos_x, res.confidence_flag, res.tip_flag,
                       res.small_value, res.second_word, res.first_word};

endmodule
